// ===== rtl/agc_pkg.sv =====
// Package with the types and constants of the automatic gain control block.
package agc_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENV_DIFF,
        S_ENV_MUL,
        S_ENV_UPD,
        S_DIV,
        S_CLAMP,
        S_GAIN_DIFF,
        S_GAIN_MUL,
        S_GAIN_UPD,
        S_OUT_MUL,
        S_OUT_FIN
    } t_state;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEVEL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAIN          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEFF      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEFF     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SMOOTH_COEFF = 3'd4;

    localparam logic [15:0] RST_TARGET_LEVEL      = 16'd3277;
    localparam logic [23:0] RST_MAX_GAIN          = 24'd655360;
    localparam logic [23:0] RST_ATTACK_COEFF      = 24'd208376;
    localparam logic [23:0] RST_RELEASE_COEFF     = 24'd2097;
    localparam logic [23:0] RST_GAIN_SMOOTH_COEFF = 24'd10483;
    localparam logic [31:0] RST_SMOOTHED_GAIN     = 32'd16777216;

    localparam logic [23:0] MIN_GAIN_Q16 = 24'd6554;
    localparam logic [55:0] HALF_Q24     = 56'd8388608;

    localparam int          DIV_STEPS = 40;
    localparam int          DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

endpackage

// ===== rtl/audio_agc_envelope_gain.sv =====
// Automatic gain control with envelope follower, built around one shared multiplier.
//
//  channel   direction  handshake                     payload
//  input     in         i_in_valid / o_in_stall       i_sample_in
//  output    out        o_out_valid / i_out_stall     o_sample_out, o_gain_now, o_clipped
//  config    in         i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// An item passes the envelope, divider, gain and output states before its result is
// registered, and the next item is accepted only once the block is back in idle, so
// items do not overlap; the division takes 40 restoring divider steps.
// The other steps share one 24 by 32 bit multiplier for envelope, gain and output.
// Reset restores the register defaults, a zero envelope and a unity smoothed gain.
// A stalled result waits in the output register while the next item is processed.
module audio_agc_envelope_gain
    import agc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [15:0]   i_sample_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [15:0]   o_sample_out,
    output logic        [23:0]   o_gain_now,
    output logic                 o_clipped,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [23:0]          i_cfg_data
);

    t_state r_state;
    t_state n_state;

    logic [15:0] r_target_level;
    logic [23:0] r_max_gain;
    logic [23:0] r_attack_coeff;
    logic [23:0] r_release_coeff;
    logic [23:0] r_gain_smooth_coeff;

    logic [23:0] r_env;
    logic [31:0] r_sg;

    logic [15:0] r_mag;
    logic        r_neg;
    logic        r_up;
    logic [23:0] r_coef;
    logic [31:0] r_diff;
    logic [55:0] r_prod;
    logic [23:0] r_rem;
    logic [39:0] r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [23:0] r_tgain;

    logic        r_out_valid;
    logic [15:0] r_sample_out;
    logic [23:0] r_gain_now;
    logic        r_clipped;

    logic        w_accept;
    logic        w_out_free;
    logic [23:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [55:0] w_rnd;
    logic [23:0] w_mag23;
    logic        w_env_up;
    logic [23:0] w_divisor;
    logic [24:0] w_trial;
    logic        w_fits;
    logic [24:0] w_trial_sub;
    logic [23:0] w_tmax;
    logic [31:0] w_tgt32;
    logic        w_gain_up;
    logic [24:0] w_out_mag;
    logic [15:0] w_out_val;
    logic        w_out_clip;

    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = signed'(r_sample_out);
    assign o_gain_now   = r_gain_now;
    assign o_clipped    = r_clipped;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_mul_a = (r_state == S_OUT_MUL) ? {8'b0, r_mag} : r_coef;
    assign w_mul_b = (r_state == S_OUT_MUL) ? r_sg : r_diff;
    assign w_rnd   = r_prod + HALF_Q24;

    assign w_mag23  = {r_mag, 8'b0};
    assign w_env_up = w_mag23 > r_env;

    assign w_divisor   = (r_env == 24'd0) ? 24'd1 : r_env;
    assign w_trial     = {r_rem, r_quo[39]};
    assign w_fits      = w_trial >= {1'b0, w_divisor};
    assign w_trial_sub = w_trial - {1'b0, w_divisor};

    assign w_tmax    = (r_quo > {16'b0, r_max_gain}) ? r_max_gain : r_quo[23:0];
    assign w_tgt32   = {r_tgain, 8'b0};
    assign w_gain_up = w_tgt32 >= r_sg;

    assign w_out_mag = w_rnd[48:24];

    always_comb begin
        if (r_neg) begin
            w_out_clip = w_out_mag > 25'd32768;
            w_out_val  = w_out_clip ? 16'h8000 : 16'(16'd0 - w_out_mag[15:0]);
        end else begin
            w_out_clip = w_out_mag > 25'd32767;
            w_out_val  = w_out_clip ? 16'h7FFF : w_out_mag[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = S_ENV_DIFF;
                end
            end
            S_ENV_DIFF:  n_state = S_ENV_MUL;
            S_ENV_MUL:   n_state = S_ENV_UPD;
            S_ENV_UPD:   n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP:     n_state = S_GAIN_DIFF;
            S_GAIN_DIFF: n_state = S_GAIN_MUL;
            S_GAIN_MUL:  n_state = S_GAIN_UPD;
            S_GAIN_UPD:  n_state = S_OUT_MUL;
            S_OUT_MUL:   n_state = S_OUT_FIN;
            S_OUT_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_level      <= RST_TARGET_LEVEL;
            r_max_gain          <= RST_MAX_GAIN;
            r_attack_coeff      <= RST_ATTACK_COEFF;
            r_release_coeff     <= RST_RELEASE_COEFF;
            r_gain_smooth_coeff <= RST_GAIN_SMOOTH_COEFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TARGET_LEVEL:      r_target_level      <= i_cfg_data[15:0];
                CFG_MAX_GAIN:          r_max_gain          <= i_cfg_data;
                CFG_ATTACK_COEFF:      r_attack_coeff      <= i_cfg_data;
                CFG_RELEASE_COEFF:     r_release_coeff     <= i_cfg_data;
                CFG_GAIN_SMOOTH_COEFF: r_gain_smooth_coeff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env <= 24'd0;
            r_sg  <= RST_SMOOTHED_GAIN;
        end else begin
            if (r_state == S_ENV_UPD) begin
                r_env <= r_up ? (r_env + w_rnd[47:24]) : (r_env - w_rnd[47:24]);
            end
            if (r_state == S_GAIN_UPD) begin
                r_sg <= r_up ? (r_sg + w_rnd[55:24]) : (r_sg - w_rnd[55:24]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg <= i_sample_in[15];
            r_mag <= i_sample_in[15] ? 16'(~i_sample_in + 16'sd1) : i_sample_in;
        end
        case (r_state)
            S_ENV_DIFF: begin
                r_up   <= w_env_up;
                r_coef <= w_env_up ? r_attack_coeff : r_release_coeff;
                r_diff <= {8'b0, (w_env_up ? (w_mag23 - r_env) : (r_env - w_mag23))};
            end
            S_ENV_UPD: begin
                r_rem <= 24'd0;
                r_quo <= {r_target_level, 24'b0};
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= w_fits ? w_trial_sub[23:0] : w_trial[23:0];
                r_quo <= {r_quo[38:0], w_fits};
                r_cnt <= r_cnt + 1'b1;
            end
            S_CLAMP: begin
                r_tgain <= (w_tmax < MIN_GAIN_Q16) ? MIN_GAIN_Q16 : w_tmax;
            end
            S_GAIN_DIFF: begin
                r_up   <= w_gain_up;
                r_coef <= r_gain_smooth_coeff;
                r_diff <= w_gain_up ? (w_tgt32 - r_sg) : (r_sg - w_tgt32);
            end
            default: ;
        endcase
        if (r_state == S_ENV_MUL || r_state == S_GAIN_MUL || r_state == S_OUT_MUL) begin
            r_prod <= 56'(w_mul_a) * 56'(w_mul_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT_FIN && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT_FIN && w_out_free) begin
            r_sample_out <= w_out_val;
            r_gain_now   <= r_sg[31:8];
            r_clipped    <= w_out_clip;
        end
    end

endmodule
